// ===== rtl/msld_pkg.sv =====
// Package for the magic-sync length-prefixed deframer.
// Holds the phase and result-kind types, register indexes and header byte positions.
// No dependencies.
package msld_pkg;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_HEADER = 3'd1,
      PH_HEAD   = 3'd2,
      PH_BODY   = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEAD_BYTE = 2'd0,
      KIND_BODY_BYTE = 2'd1,
      KIND_DONE      = 2'd2,
      KIND_VER_ERROR = 2'd3
   } kind_type;

   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAGIC   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERSION = 1'd1;

   localparam logic [63:0] MAGIC_RESET   = 64'd0;
   localparam logic [31:0] VERSION_RESET = 32'd65536;

   // window fill saturates once a full magic word has been seen
   localparam logic [3:0] WINDOW_BYTES = 4'd8;

   // header byte count after the byte that completes each header field;
   // the count wraps to zero on the sixteenth byte
   localparam logic [3:0] HDR_VERSION_DONE  = 4'd4;
   localparam logic [3:0] HDR_HEADLEN_DONE  = 4'd8;
   localparam logic [3:0] HDR_BODYLEN_DONE  = 4'd0;

endpackage

// ===== rtl/magic_sync_length_prefixed_deframer.sv =====
// Magic-sync length-prefixed deframer, top level.
// Hunts for the magic word, parses the 16-byte header and streams head and body bytes.
// Depends on msld_pkg.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_data_byte     | in  (stall driven out)
//   rsp     | rsp_valid, rsp_stall, rsp_out_byte,     | out (stall driven in)
//           | rsp_result_kind, rsp_head_last,         |
//           | rsp_frame_last                          |
//   csr     | csr_wr_en, csr_index, csr_wr_data       | in  (write only)
//
// One byte per clock sustained while the rsp side does not stall; each beat is held in
// the input register and then moves to the result register, which drives the rsp
// ports until the result is taken.
// The input register takes a new beat while a result waits, and stalls only when
// both the input and the result register are full and rsp_stall is high.
// Synchronous reset returns to hunting with an empty window; no clearing pass.
module magic_sync_length_prefixed_deframer #(
   parameter int HEAD_LEN_BITS = 32,
   parameter int BODY_LEN_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_head_last,
   output logic        rsp_frame_last,

   input  logic                                csr_wr_en,
   input  logic [msld_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [63:0]                         csr_wr_data
);

   // configuration
   logic [63:0] magic_ff;
   logic [31:0] version_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   // parser state
   msld_pkg::phase_type      phase_ff, phase_in;
   logic [63:0]              sync_window_ff, sync_window_in;
   logic [3:0]               window_fill_ff, window_fill_in;
   logic [3:0]               hdr_count_ff, hdr_count_in;
   logic [63:0]              hdr_shift_ff, hdr_shift_in;
   logic [HEAD_LEN_BITS-1:0] head_left_ff, head_left_in;
   logic [BODY_LEN_BITS-1:0] body_left_ff, body_left_in;

   // result register
   logic                rsp_valid_ff;
   logic [7:0]          rsp_byte_ff, res_byte;
   msld_pkg::kind_type  rsp_kind_ff, res_kind;
   logic                rsp_hl_ff, res_hl;
   logic                rsp_fl_ff, res_fl;
   logic                res_valid;

   // step helpers
   logic                     advance;
   logic                     step_fire;
   logic [63:0]              hdr_shift_step;
   logic [3:0]               hdr_count_step;
   logic [63:0]              window_step;
   logic [3:0]               fill_step;
   logic [HEAD_LEN_BITS-1:0] head_dec;
   logic [BODY_LEN_BITS-1:0] body_dec;
   logic [HEAD_LEN_BITS-1:0] head_sat;
   logic [BODY_LEN_BITS-1:0] body_sat;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_head_last   = rsp_hl_ff;
   assign rsp_frame_last  = rsp_fl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= msld_pkg::MAGIC_RESET;
         version_ff <= msld_pkg::VERSION_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == msld_pkg::CSR_MAGIC) begin
            magic_ff <= csr_wr_data;
         end
         if (csr_index == msld_pkg::CSR_VERSION) begin
            version_ff <= csr_wr_data[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   always_comb begin
      hdr_shift_step = {hdr_shift_ff[55:0], in_byte_ff};
      hdr_count_step = hdr_count_ff + 4'd1;
      window_step    = {sync_window_ff[55:0], in_byte_ff};
      fill_step      = (window_fill_ff < msld_pkg::WINDOW_BYTES) ?
                       window_fill_ff + 4'd1 : window_fill_ff;
      head_dec       = head_left_ff - {{(HEAD_LEN_BITS-1){1'b0}}, 1'b1};
      body_dec       = body_left_ff - {{(BODY_LEN_BITS-1){1'b0}}, 1'b1};
      // oversized lengths saturate to the counter maximum
      head_sat       = ((hdr_shift_step[31:0] >> HEAD_LEN_BITS) != 32'd0) ?
                       '1 : hdr_shift_step[HEAD_LEN_BITS-1:0];
      body_sat       = ((hdr_shift_step >> BODY_LEN_BITS) != 64'd0) ?
                       '1 : hdr_shift_step[BODY_LEN_BITS-1:0];
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      sync_window_in = sync_window_ff;
      window_fill_in = window_fill_ff;
      hdr_count_in   = hdr_count_ff;
      hdr_shift_in   = hdr_shift_ff;
      head_left_in   = head_left_ff;
      body_left_in   = body_left_ff;
      case (phase_ff)
         msld_pkg::PH_HEADER: begin
            hdr_shift_in = hdr_shift_step;
            hdr_count_in = hdr_count_step;
            if (hdr_count_step == msld_pkg::HDR_VERSION_DONE) begin
               if (hdr_shift_step[31:0] != version_ff) begin
                  phase_in = msld_pkg::PH_HUNT;
               end
            end else if (hdr_count_step == msld_pkg::HDR_HEADLEN_DONE) begin
               head_left_in = head_sat;
            end else if (hdr_count_step == msld_pkg::HDR_BODYLEN_DONE) begin
               body_left_in = body_sat;
               if (head_left_ff != '0) begin
                  phase_in = msld_pkg::PH_HEAD;
               end else if (body_sat != '0) begin
                  phase_in = msld_pkg::PH_BODY;
               end else begin
                  phase_in = msld_pkg::PH_HUNT;
               end
            end
         end
         msld_pkg::PH_HEAD: begin
            head_left_in = head_dec;
            if (head_dec == '0) begin
               phase_in = (body_left_ff == '0) ? msld_pkg::PH_HUNT : msld_pkg::PH_BODY;
            end
         end
         msld_pkg::PH_BODY: begin
            body_left_in = body_dec;
            if (body_dec == '0) begin
               phase_in = msld_pkg::PH_HUNT;
            end
         end
         default: begin
            phase_in       = msld_pkg::PH_HUNT;
            sync_window_in = window_step;
            window_fill_in = fill_step;
            if (fill_step >= msld_pkg::WINDOW_BYTES && window_step == magic_ff) begin
               phase_in     = msld_pkg::PH_HEADER;
               hdr_count_in = 4'd0;
               hdr_shift_in = 64'd0;
               head_left_in = '0;
               body_left_in = '0;
            end
         end
      endcase
      // leaving a frame or header for the hunt clears the window
      if (phase_ff != msld_pkg::PH_HUNT && phase_in == msld_pkg::PH_HUNT) begin
         sync_window_in = 64'd0;
         window_fill_in = 4'd0;
         hdr_count_in   = 4'd0;
         hdr_shift_in   = 64'd0;
      end
   end

   // result of the step
   always_comb begin
      res_valid = 1'b0;
      res_byte  = 8'd0;
      res_kind  = msld_pkg::KIND_HEAD_BYTE;
      res_hl    = 1'b0;
      res_fl    = 1'b0;
      case (phase_ff)
         msld_pkg::PH_HEADER: begin
            if (hdr_count_step == msld_pkg::HDR_VERSION_DONE) begin
               if (hdr_shift_step[31:0] != version_ff) begin
                  res_valid = 1'b1;
                  res_kind  = msld_pkg::KIND_VER_ERROR;
               end
            end else if (hdr_count_step == msld_pkg::HDR_BODYLEN_DONE) begin
               if (head_left_ff == '0 && body_sat == '0) begin
                  res_valid = 1'b1;
                  res_kind  = msld_pkg::KIND_DONE;
                  res_fl    = 1'b1;
               end
            end
         end
         msld_pkg::PH_HEAD: begin
            res_valid = 1'b1;
            res_byte  = in_byte_ff;
            res_kind  = msld_pkg::KIND_HEAD_BYTE;
            res_hl    = (head_dec == '0);
            res_fl    = (head_dec == '0) && (body_left_ff == '0);
         end
         msld_pkg::PH_BODY: begin
            res_valid = 1'b1;
            res_byte  = in_byte_ff;
            res_kind  = msld_pkg::KIND_BODY_BYTE;
            res_fl    = (body_dec == '0);
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= msld_pkg::PH_HUNT;
         sync_window_ff <= 64'd0;
         window_fill_ff <= 4'd0;
         hdr_count_ff   <= 4'd0;
         hdr_shift_ff   <= 64'd0;
         head_left_ff   <= '0;
         body_left_ff   <= '0;
      end else if (step_fire) begin
         phase_ff       <= phase_in;
         sync_window_ff <= sync_window_in;
         window_fill_ff <= window_fill_in;
         hdr_count_ff   <= hdr_count_in;
         hdr_shift_ff   <= hdr_shift_in;
         head_left_ff   <= head_left_in;
         body_left_ff   <= body_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step_fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && res_valid) begin
         rsp_byte_ff <= res_byte;
         rsp_kind_ff <= res_kind;
         rsp_hl_ff   <= res_hl;
         rsp_fl_ff   <= res_fl;
      end
   end

   // a head or body phase always has bytes left to pass
   a_head_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == msld_pkg::PH_HEAD |-> head_left_ff != '0)
      else $error("head phase with zero head count");

   a_body_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == msld_pkg::PH_BODY |-> body_left_ff != '0)
      else $error("body phase with zero body count");

   // any frame-ending result puts the parser back to hunting with an empty window
   a_frame_end_hunts: assert property (@(posedge clock) disable iff (reset)
      step_fire && res_valid && res_fl |=>
         phase_ff == msld_pkg::PH_HUNT && window_fill_ff == 4'd0)
      else $error("frame end did not restart hunt");

   // the input side stalls only behind a held result
   a_stall_needs_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled with free result register");

   a_hunt_header_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff == msld_pkg::PH_HUNT |-> hdr_count_ff == 4'd0)
      else $error("header count running while hunting");

endmodule
